/* rtl/core/bfpv_pkg.sv */
// Shared types, codes and helpers for the bit-field packer with LEB128 varints.
package bfpv_pkg;

    localparam int VARINT_BYTE_LIMIT = 10;

    localparam int IN_TDATA_W  = 208;
    localparam int OUT_TDATA_W = 8;
    localparam int OUT_TUSER_W = 4;

    // Command codes; codes 6 and 7 carry no meaning and act as no-ops.
    localparam logic [2:0] CMD_RAW   = 3'd0;
    localparam logic [2:0] CMD_RANGE = 3'd1;
    localparam logic [2:0] CMD_UVAR  = 3'd2;
    localparam logic [2:0] CMD_SVAR  = 3'd3;
    localparam logic [2:0] CMD_ALIGN = 3'd4;
    localparam logic [2:0] CMD_END   = 3'd5;

    // Status codes.
    localparam logic [2:0] STS_OK           = 3'd0;
    localparam logic [2:0] STS_FAILED       = 3'd1;
    localparam logic [2:0] STS_TOO_WIDE     = 3'd2;
    localparam logic [2:0] STS_RANGE_INV    = 3'd3;
    localparam logic [2:0] STS_OUT_OF_RANGE = 3'd4;
    localparam logic [2:0] STS_BAD_LIMIT    = 3'd5;
    localparam logic [2:0] STS_TOO_LONG     = 3'd6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_RNG_INV,
        ST_RNG_HI,
        ST_RNG_LO,
        ST_RNG_SPAN,
        ST_RNG_WIDTH,
        ST_PUT,
        ST_ALIGN,
        ST_VAR_BYTE,
        ST_FLUSH,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last_of_run;
        logic [2:0] status;
    } out_item_t;

    // Operands for the shared subtract/compare and shift-check unit.
    typedef struct packed {
        logic [63:0] sub_a;
        logic [63:0] sub_b;
        logic [63:0] chk_val;
        logic [6:0]  chk_sh;
    } alu_req_t;

    typedef struct packed {
        logic [63:0] diff;   // sub_a - sub_b, modulo 2^64
        logic        neg;    // signed sub_a < signed sub_b
        logic        over;   // chk_val has a set bit at or above chk_sh
    } alu_rsp_t;

    function automatic logic [63:0] zigzag(input logic [63:0] v);
        zigzag = {v[62:0], 1'b0} ^ {64{v[63]}};
    endfunction

    // Payload bits that fit in lim varint bytes: 7 * lim.
    function automatic logic [6:0] varint_bits(input logic [3:0] lim);
        varint_bits = ({3'b000, lim} << 3) - {3'b000, lim};
    endfunction

endpackage

/* rtl/core/bit_field_packer_varint_top.sv */
// Top level of the LSB-first bit packer with LEB128/zigzag varints.
// Flow: a taken command is registered and dispatched, and its first result beat is held in the
// output register; a ranged value first passes the RNG_INV, RNG_HI, RNG_LO and RNG_SPAN states and
// a span width scan. One command at a time, as set by the single shared subtract/shift unit and
// sequencer; a full output register stalls the sequencer and lengthens the command.
// Reset (aresetn low, synchronous): empty partial byte, bit phase 0, stream healthy.
module bit_field_packer_varint_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // command[2:0], data_value[66:3], bit_width[73:67], range_low[137:74],
    // range_high[201:138], byte_cap[205:202], zero fill [207:206]
    input  logic [bfpv_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [bfpv_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // out_byte[7:0]
    output logic [bfpv_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,  // byte_valid[0], status[3:1]
    output logic                              m_axis_tlast   // last_of_run
);
    import bfpv_pkg::*;

    alu_req_t  alu_req;
    alu_rsp_t  alu_rsp;
    out_item_t item;
    logic      push;
    logic      out_free;

    // Shared arithmetic: signed compares, range offset and span, high-bit checks.
    bfpv_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // Sequencer: unpack the beat fields and step through the command.
    bfpv_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .command    (s_axis_tdata[2:0]),
        .data_value (s_axis_tdata[66:3]),
        .bit_width  (s_axis_tdata[73:67]),
        .range_low  (s_axis_tdata[137:74]),
        .range_high (s_axis_tdata[201:138]),
        .byte_cap   (s_axis_tdata[205:202]),
        .alu_req    (alu_req),
        .alu_rsp    (alu_rsp),
        .out_free   (out_free),
        .push       (push),
        .item       (item)
    );

    // Hold each result beat until the sink takes it.
    bfpv_obuf u_obuf (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .push          (push),
        .item          (item),
        .out_free      (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

/* rtl/core/bfpv_alu.sv */
// Shared 65-bit subtract/compare and high-bit check unit.
module bfpv_alu (
    input  bfpv_pkg::alu_req_t req,
    output bfpv_pkg::alu_rsp_t rsp
);
    import bfpv_pkg::*;

    logic [64:0] wide_diff;
    logic [63:0] shifted;

    assign wide_diff = {req.sub_a[63], req.sub_a} - {req.sub_b[63], req.sub_b};
    assign shifted   = req.chk_val >> req.chk_sh;

    assign rsp.diff = wide_diff[63:0];
    assign rsp.neg  = wide_diff[64];
    assign rsp.over = |shifted;

endmodule

/* rtl/core/bfpv_obuf.sv */
// Output register that parts the sequencer from the result stream.
module bfpv_obuf (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          push,
    input  bfpv_pkg::out_item_t           item,
    output logic                          out_free,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [bfpv_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // out_byte
    output logic [bfpv_pkg::OUT_TUSER_W-1:0] m_axis_tuser,  // byte_valid, status[2:0]
    output logic                          m_axis_tlast    // last_of_run
);
    import bfpv_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;

    assign out_free = !valid_reg || m_axis_tready;

    always_comb begin
        valid_next = valid_reg;
        if (push) begin
            valid_next = 1'b1;
        end else if (m_axis_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            item_reg <= item;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = item_reg.out_byte;
    assign m_axis_tuser  = {item_reg.status, item_reg.byte_valid};
    assign m_axis_tlast  = item_reg.last_of_run;

endmodule

/* rtl/core/bfpv_seq.sv */
// Command sequencer: bit phase, partial byte, health flag and emission steps.
module bfpv_seq (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          command,
    input  logic [63:0]         data_value,
    input  logic [6:0]          bit_width,
    input  logic [63:0]         range_low,
    input  logic [63:0]         range_high,
    input  logic [3:0]          byte_cap,
    output bfpv_pkg::alu_req_t  alu_req,
    input  bfpv_pkg::alu_rsp_t  alu_rsp,
    input  logic                out_free,
    output logic                push,
    output bfpv_pkg::out_item_t item
);
    import bfpv_pkg::*;

    state_t      state_reg, state_next;
    logic [2:0]  cmd_reg;
    logic [63:0] val_reg, lo_reg, hi_reg, hi_next;
    logic [6:0]  width_reg;
    logic [3:0]  limit_reg;
    logic [63:0] work_reg, work_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [3:0]  vcnt_reg, vcnt_next;
    logic [7:0]  pending_reg, pending_next;
    logic [2:0]  phase_reg, phase_next;
    logic        healthy_reg, healthy_next;
    logic [2:0]  status_reg, status_next;
    logic        emitted_reg, emitted_next;

    logic        accept;
    logic        is_var;
    logic        bad_limit;
    logic        raw_bad;
    logic [3:0]  room;
    logic [3:0]  take;
    logic [7:0]  chunk_mask;
    logic [7:0]  merged;
    logic [3:0]  new_phase;
    logic [6:0]  cnt_rem;
    logic        byte_done;
    logic        put_stall;
    logic [63:0] var_rest;
    logic        var_cont;
    logic        var_last;
    logic        scan_wide;
    logic        scan_any;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    assign is_var    = (cmd_reg == CMD_UVAR) || (cmd_reg == CMD_SVAR);
    assign bad_limit = (limit_reg == 4'd0) || (limit_reg > 4'(VARINT_BYTE_LIMIT));
    assign raw_bad   = (width_reg > 7'd64) || alu_rsp.over;

    // Bit emission step.
    assign room       = 4'd8 - {1'b0, phase_reg};
    assign take       = (cnt_reg < {3'b000, room}) ? cnt_reg[3:0] : room;
    assign chunk_mask = 8'hff >> (4'd8 - take);
    assign merged     = pending_reg | ((work_reg[7:0] & chunk_mask) << phase_reg);
    assign new_phase  = {1'b0, phase_reg} + take;
    assign cnt_rem    = cnt_reg - {3'b000, take};
    assign byte_done  = new_phase[3];
    assign put_stall  = byte_done && !out_free;

    // Varint byte step.
    assign var_rest = work_reg >> 7;
    assign var_cont = |var_rest;
    assign var_last = !var_cont || ((vcnt_reg + 4'd1) == limit_reg);

    // Span width scan: a byte at a time, then a bit at a time.
    assign scan_wide = |hi_reg[63:8];
    assign scan_any  = |hi_reg;

    // Operand selection for the shared unit.
    always_comb begin
        alu_req.sub_a   = hi_reg;
        alu_req.sub_b   = lo_reg;
        alu_req.chk_val = (cmd_reg == CMD_SVAR) ? zigzag(val_reg) : val_reg;
        alu_req.chk_sh  = (cmd_reg == CMD_RAW) ? width_reg : varint_bits(limit_reg);
        unique case (state_reg)
            ST_RNG_HI: begin
                alu_req.sub_a = hi_reg;
                alu_req.sub_b = val_reg;
            end
            ST_RNG_LO: begin
                alu_req.sub_a = val_reg;
                alu_req.sub_b = lo_reg;
            end
            default: begin
                alu_req.sub_a = hi_reg;
                alu_req.sub_b = lo_reg;
            end
        endcase
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) state_next = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                priority if (cmd_reg == CMD_END) begin
                    state_next = (phase_reg != 3'd0) ? ST_FLUSH : ST_FINISH;
                end else if (!healthy_reg) begin
                    state_next = ST_FINISH;
                end else if (cmd_reg == CMD_RAW) begin
                    state_next = (raw_bad || width_reg == 7'd0) ? ST_FINISH : ST_PUT;
                end else if (cmd_reg == CMD_RANGE) begin
                    state_next = ST_RNG_INV;
                end else if (is_var) begin
                    if (bad_limit) begin
                        state_next = ST_FINISH;
                    end else begin
                        state_next = (phase_reg != 3'd0) ? ST_ALIGN : ST_VAR_BYTE;
                    end
                end else if (cmd_reg == CMD_ALIGN) begin
                    state_next = (phase_reg != 3'd0) ? ST_ALIGN : ST_FINISH;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_RNG_INV:  state_next = alu_rsp.neg ? ST_FINISH : ST_RNG_HI;
            ST_RNG_HI:   state_next = alu_rsp.neg ? ST_FINISH : ST_RNG_LO;
            ST_RNG_LO:   state_next = alu_rsp.neg ? ST_FINISH : ST_RNG_SPAN;
            ST_RNG_SPAN: state_next = ST_RNG_WIDTH;
            ST_RNG_WIDTH: begin
                if (!scan_any) state_next = (cnt_reg == 7'd0) ? ST_FINISH : ST_PUT;
            end
            ST_PUT: begin
                if (!put_stall && cnt_rem == 7'd0) state_next = ST_FINISH;
            end
            ST_ALIGN: begin
                if (out_free) state_next = is_var ? ST_VAR_BYTE : ST_FINISH;
            end
            ST_VAR_BYTE: begin
                if (out_free && var_last) state_next = ST_FINISH;
            end
            ST_FLUSH: begin
                if (out_free) state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (emitted_reg || out_free) state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath updates and result pushes.
    always_comb begin
        work_next    = work_reg;
        cnt_next     = cnt_reg;
        vcnt_next    = vcnt_reg;
        hi_next      = hi_reg;
        pending_next = pending_reg;
        phase_next   = phase_reg;
        healthy_next = healthy_reg;
        status_next  = status_reg;
        emitted_next = emitted_reg;
        push         = 1'b0;
        item         = '{out_byte: pending_reg, byte_valid: 1'b1,
                         last_of_run: 1'b1, status: status_reg};
        if (accept) hi_next = range_high;
        unique case (state_reg)
            ST_IDLE: begin
            end
            ST_DISPATCH: begin
                emitted_next = 1'b0;
                status_next  = STS_OK;
                vcnt_next    = 4'd0;
                priority if (cmd_reg == CMD_END) begin
                    status_next  = healthy_reg ? STS_OK : STS_FAILED;
                    healthy_next = 1'b1;
                end else if (!healthy_reg) begin
                    status_next = STS_FAILED;
                end else if (cmd_reg == CMD_RAW) begin
                    if (raw_bad && width_reg != 7'd0) begin
                        status_next  = STS_TOO_WIDE;
                        healthy_next = 1'b0;
                    end
                    work_next = val_reg;
                    cnt_next  = width_reg;
                end else if (is_var) begin
                    work_next = alu_req.chk_val;
                    if (bad_limit) begin
                        status_next  = STS_BAD_LIMIT;
                        healthy_next = 1'b0;
                    end else if (alu_rsp.over) begin
                        status_next  = STS_TOO_LONG;
                        healthy_next = 1'b0;
                    end
                end else begin
                    // Ranged values check in the next steps; align and spare codes hold here.
                end
            end
            ST_RNG_INV: begin
                if (alu_rsp.neg) begin
                    status_next  = STS_RANGE_INV;
                    healthy_next = 1'b0;
                end
            end
            ST_RNG_HI: begin
                if (alu_rsp.neg) begin
                    status_next  = STS_OUT_OF_RANGE;
                    healthy_next = 1'b0;
                end
            end
            ST_RNG_LO: begin
                work_next = alu_rsp.diff;
                if (alu_rsp.neg) begin
                    status_next  = STS_OUT_OF_RANGE;
                    healthy_next = 1'b0;
                end
            end
            ST_RNG_SPAN: begin
                hi_next  = alu_rsp.diff;
                cnt_next = 7'd0;
            end
            ST_RNG_WIDTH: begin
                if (scan_wide) begin
                    hi_next  = hi_reg >> 8;
                    cnt_next = cnt_reg + 7'd8;
                end else if (scan_any) begin
                    hi_next  = hi_reg >> 1;
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            ST_PUT: begin
                if (!put_stall) begin
                    work_next = work_reg >> take;
                    cnt_next  = cnt_rem;
                    if (byte_done) begin
                        push         = 1'b1;
                        item         = '{out_byte: merged, byte_valid: 1'b1,
                                         last_of_run: (cnt_rem < 7'd8), status: status_reg};
                        pending_next = 8'd0;
                        phase_next   = 3'd0;
                        emitted_next = 1'b1;
                    end else begin
                        pending_next = merged;
                        phase_next   = new_phase[2:0];
                    end
                end
            end
            ST_ALIGN: begin
                if (out_free) begin
                    push         = 1'b1;
                    item         = '{out_byte: pending_reg, byte_valid: 1'b1,
                                     last_of_run: (cmd_reg == CMD_ALIGN), status: status_reg};
                    pending_next = 8'd0;
                    phase_next   = 3'd0;
                    emitted_next = 1'b1;
                end
            end
            ST_VAR_BYTE: begin
                if (out_free) begin
                    push         = 1'b1;
                    item         = '{out_byte: {var_cont, work_reg[6:0]}, byte_valid: 1'b1,
                                     last_of_run: var_last, status: status_reg};
                    work_next    = var_rest;
                    vcnt_next    = vcnt_reg + 4'd1;
                    emitted_next = 1'b1;
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    push         = 1'b1;
                    pending_next = 8'd0;
                    phase_next   = 3'd0;
                    emitted_next = 1'b1;
                end
            end
            ST_FINISH: begin
                if (!emitted_reg && out_free) begin
                    push = 1'b1;
                    item = '{out_byte: 8'd0, byte_valid: 1'b0,
                             last_of_run: 1'b1, status: status_reg};
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pending_reg <= 8'd0;
            phase_reg   <= 3'd0;
            healthy_reg <= 1'b1;
        end else begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
            phase_reg   <= phase_next;
            healthy_reg <= healthy_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg   <= command;
            val_reg   <= data_value;
            width_reg <= bit_width;
            lo_reg    <= range_low;
            limit_reg <= byte_cap;
        end
        hi_reg      <= hi_next;
        work_reg    <= work_next;
        cnt_reg     <= cnt_next;
        vcnt_reg    <= vcnt_next;
        status_reg  <= status_next;
        emitted_reg <= emitted_next;
    end

`ifndef NO_ASSERTIONS
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> out_free)
        else $error("result pushed while output register is occupied");

    a_var_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_VAR_BYTE) |-> (phase_reg == 3'd0))
        else $error("varint byte emitted on an unaligned stream");

    a_var_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_VAR_BYTE) |-> (vcnt_reg < limit_reg))
        else $error("varint ran past its byte limit");

    a_put_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PUT) |-> (cnt_reg != 7'd0))
        else $error("bit emission entered with nothing to write");

    a_end_heals: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DISPATCH && cmd_reg == CMD_END) |=> healthy_reg)
        else $error("end did not restore stream health");
`endif

endmodule
